// File: src/mwo_pkg.sv
// Shared types, constants and register map of the multi-waveform oscillator.
package mwo_pkg;

    localparam int PHASE_BITS_DEF  = 32;
    localparam int SINE_DEPTH_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int FREQ_W = 24;
    localparam int AMP_W  = 16;
    localparam int PPH_W  = 24;
    localparam int KNEE_W = 16;
    localparam int WAVE_W = 3;
    localparam int U_W    = 16;
    localparam int Y_W    = 18;
    localparam int DIV_NW = 32;
    localparam int DIV_DW = 17;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [WAVE_W-1:0] WAVE_SINE  = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_SQSAW = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_SAW   = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_SINE5 = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_TRI   = 3'd4;
    localparam logic [WAVE_W-1:0] WAVE_MORPH = 3'd5;

    localparam logic [1:0] REG_WAVE = 2'd0;
    localparam logic [1:0] REG_AMP  = 2'd1;
    localparam logic [1:0] REG_PPH  = 2'd2;
    localparam logic [1:0] REG_KNEE = 2'd3;

    localparam logic [WAVE_W-1:0] WAVE_RST = WAVE_MORPH;
    localparam logic [AMP_W-1:0]  AMP_RST  = 16'd13107;
    localparam logic [PPH_W-1:0]  PPH_RST  = 24'd89478;
    localparam logic [KNEE_W-1:0] KNEE_RST = 16'd8000;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_ROM, S_POW1, S_POW2, S_POW3, S_KDIV, S_KWAIT,
        S_SDIV, S_SWAIT, S_SHAPE, S_GAIN, S_HOLD
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_PREP, OP_ROM, OP_POW1, OP_POW2, OP_POW3,
        OP_KSTART, OP_KTAKE, OP_SSTART, OP_SHAPE, OP_GAIN, OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic k_big;
        logic div_busy;
        logic div_done;
        logic out_busy;
    } t_status;

    typedef struct packed {
        logic [WAVE_W-1:0] waveform;
        logic [AMP_W-1:0]  amplitude;
        logic [PPH_W-1:0]  phase_per_hz;
        logic [KNEE_W-1:0] morph_knee_hz;
    } t_cfg;

endpackage

// File: src/mwo_if.sv
// Input and output channel interfaces of the oscillator.
interface mwo_in_if import mwo_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] freq_q8;
    modport source (output valid, output freq_q8, input ready);
    modport sink (input valid, input freq_q8, output ready);
endinterface

interface mwo_out_if #(parameter int SAMPLE_BITS = 16) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clipped;
    modport source (output valid, output sample, output clipped, input ready);
    modport sink (input valid, input sample, input clipped, output ready);
endinterface

// File: src/mwo_div.sv
// Restoring divider, one quotient bit per cycle.
module mwo_div import mwo_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output logic              o_busy,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_div;
    logic [DIV_DW:0]   w_shift;
    logic [DIV_DW:0]   w_diff;
    logic              w_ge;

    assign w_shift = {r_rem, r_quo[DIV_NW-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_ge    = w_shift >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(DIV_NW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_shift[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: src/mwo_dp.sv
// Oscillator datapath: phase accumulator, sine ROM, shaping, gain and saturation.
module mwo_dp import mwo_pkg::*; #(
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  t_cfg                          i_cfg,
    input  logic [FREQ_W-1:0]             i_freq_q8,
    input  logic                          i_out_ready,
    output t_status                       o_st,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_clipped
);

    localparam int IW     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IDXP_W = PHASE_BITS - 2 + IW;
    localparam int INC_W  = FREQ_W + PPH_W;
    localparam int EXT_W  = PHASE_BITS + INC_W;
    localparam int P_W    = Y_W + AMP_W + 1;
    localparam int SHIFT  = 30 - SAMPLE_BITS;
    localparam logic signed [P_W-1:0] RND  = P_W'(1) <<< (SHIFT - 1);
    localparam logic signed [P_W-1:0] MAXV = P_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [P_W-1:0] MINV = -(P_W'(1) <<< (SAMPLE_BITS - 1));
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef logic [14:0] t_rom [0:SINE_TABLE_DEPTH];

    function automatic t_rom f_build();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x  = 64'(i) * HALF_PI_Q30 / 64'(SINE_TABLE_DEPTH);
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            for (int n = 7; n >= 1; n--) begin
                t = ONE_Q30 - ((x2 * t) >> 30) / 64'((2 * n) * (2 * n + 1));
            end
            v = (((x * t) >> 30) + 64'd16384) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            rom[i] = v[14:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = f_build();

    function automatic logic [15:0] f_q15(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        p = 32'(a) * 32'(b) + 32'd16384;
        return p[30:15];
    endfunction

    logic [PHASE_BITS-1:0]   r_phase;
    logic [PHASE_BITS-1:0]   r_ph;
    logic [FREQ_W-1:0]       r_freq;
    logic [INC_W-1:0]        r_inc;
    logic [IW-1:0]           r_addr;
    logic [14:0]             r_rom;
    logic [15:0]             r_m;
    logic                    r_k_big;
    logic [DIV_DW-1:0]       r_k;
    logic                    r_lower;
    logic                    r_nneg;
    logic signed [Y_W-1:0]   r_y;
    logic signed [P_W-1:0]   r_prod;
    logic                    r_out_valid;
    logic [SAMPLE_BITS-1:0]  r_sample;
    logic                    r_clipped;

    logic [U_W-1:0]          w_u;
    logic [1:0]              w_quarter;
    logic [IDXP_W-1:0]       w_idxp;
    logic [IW-1:0]           w_idx;
    logic [EXT_W-1:0]        w_inc_ext;
    logic                    w_div_start;
    logic [DIV_NW-1:0]       w_dividend;
    logic [DIV_DW-1:0]       w_divisor;
    logic                    w_div_busy;
    logic                    w_div_done;
    logic [DIV_NW-1:0]       w_quo;
    logic signed [18:0]      w_n;
    logic [16:0]             w_nmag;
    logic [16:0]             w_sq_in;
    logic [33:0]             w_sq;
    logic [15:0]             w_sq_val;
    logic signed [Y_W-1:0]   n_y;
    logic signed [P_W-1:0]   w_rsum;
    logic signed [P_W-1:0]   w_rsh;
    logic [SAMPLE_BITS-1:0]  w_sat;
    logic                    w_clip;

    assign w_u       = r_ph[PHASE_BITS-1 -: U_W];
    assign w_quarter = r_ph[PHASE_BITS-1 -: 2];
    assign w_idxp    = IDXP_W'(r_ph[PHASE_BITS-3:0]) * IDXP_W'(SINE_TABLE_DEPTH)
                     + (IDXP_W'(1) << (PHASE_BITS - 3));
    assign w_idx     = w_idxp[IDXP_W-1 -: IW];
    assign w_inc_ext = EXT_W'(r_inc[INC_W-1:8]);

    // Second morph divide: falling edge below the knee, rising edge above it
    assign w_n    = $signed({2'b00, w_u, 1'b0}) - 19'sd65536 - $signed({2'b00, r_k});
    assign w_nmag = w_n[18] ? 17'(-w_n) : w_n[16:0];

    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = {w_u, 16'd0};
        w_divisor   = r_k;
        case (i_cmd.op)
            OP_KSTART: begin
                w_div_start = 1'b1;
                w_dividend  = DIV_NW'(r_freq) << 7;
                w_divisor   = DIV_DW'(i_cfg.morph_knee_hz);
            end
            OP_SSTART: begin
                w_div_start = 1'b1;
                if (!({1'b0, w_u} < r_k)) begin
                    w_dividend = DIV_NW'(w_nmag) << 15;
                    w_divisor  = 17'd65536 - r_k;
                end
            end
            default: begin
            end
        endcase
    end

    mwo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_sq_in  = w_u[15] ? 17'd65536 - 17'(w_u) : 17'(w_u);
    assign w_sq     = 34'(w_sq_in) * 34'(w_sq_in) + 34'd32768;
    assign w_sq_val = w_sq[31:16];

    always_comb begin
        case (i_cfg.waveform)
            WAVE_SINE:  n_y = w_quarter[1] ? -Y_W'($signed({1'b0, r_rom}))
                                           : Y_W'($signed({1'b0, r_rom}));
            WAVE_SQSAW: n_y = w_u[15] ? -Y_W'($signed({1'b0, w_sq_val}))
                                      : Y_W'($signed({1'b0, w_sq_val}));
            WAVE_SAW:   n_y = w_u[15] ? -Y_W'($signed({1'b0, 17'(17'd65536 - 17'(w_u)) >> 1}))
                                      : Y_W'($signed({2'b00, w_u[15:1]}));
            WAVE_SINE5: n_y = w_quarter[1] ? -Y_W'($signed({1'b0, r_m}))
                                           : Y_W'($signed({1'b0, r_m}));
            WAVE_TRI:   n_y = w_u[15] ? Y_W'($signed({1'b0, w_u, 1'b0})) - 18'sd98304
                                      : 18'sd32768 - Y_W'($signed({1'b0, w_u, 1'b0}));
            WAVE_MORPH: begin
                if (r_lower) begin
                    n_y = 18'sd32768 - Y_W'($signed({1'b0, w_quo[16:0]}));
                end else begin
                    n_y = r_nneg ? -Y_W'($signed({1'b0, w_quo[16:0]}))
                                 : Y_W'($signed({1'b0, w_quo[16:0]}));
                end
            end
            default:    n_y = '0;
        endcase
    end

    assign w_rsum = r_prod + RND;
    assign w_rsh  = w_rsum >>> SHIFT;

    always_comb begin
        w_clip = 1'b0;
        w_sat  = w_rsh[SAMPLE_BITS-1:0];
        if (w_rsh > MAXV) begin
            w_clip = 1'b1;
            w_sat  = MAXV[SAMPLE_BITS-1:0];
        end else if (w_rsh < MINV) begin
            w_clip = 1'b1;
            w_sat  = MINV[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_PREP) begin
                r_phase <= r_phase + w_inc_ext[PHASE_BITS-1:0];
            end
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_freq <= i_freq_q8;
                r_ph   <= r_phase;
                r_inc  <= INC_W'(i_freq_q8) * INC_W'(i_cfg.phase_per_hz);
            end
            OP_PREP: begin
                r_addr  <= w_quarter[0] ? IW'(SINE_TABLE_DEPTH) - w_idx : w_idx;
                r_k_big <= r_freq >= {i_cfg.morph_knee_hz, 8'd0};
                r_k     <= 17'd32768;
            end
            OP_ROM:    r_rom <= SINE_ROM[r_addr];
            OP_POW1:   r_m <= f_q15({1'b0, r_rom}, {1'b0, r_rom});
            OP_POW2:   r_m <= f_q15(r_m, r_m);
            OP_POW3:   r_m <= f_q15(r_m, {1'b0, r_rom});
            OP_KTAKE:  r_k <= (w_quo == '0) ? 17'd1 : w_quo[16:0];
            OP_SSTART: begin
                r_lower <= {1'b0, w_u} < r_k;
                r_nneg  <= w_n[18];
            end
            OP_SHAPE:  r_y <= n_y;
            OP_GAIN:   r_prod <= P_W'(r_y) * P_W'($signed({1'b0, i_cfg.amplitude}));
            OP_OUT: begin
                r_sample  <= w_sat;
                r_clipped <= w_clip;
            end
            default: begin
            end
        endcase
    end

    assign o_st.k_big    = r_k_big;
    assign o_st.div_busy = w_div_busy;
    assign o_st.div_done = w_div_done;
    assign o_st.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid   = r_out_valid;
    assign o_sample      = $signed(r_sample);
    assign o_clipped     = r_clipped;

endmodule

// File: src/mwo_ctrl.sv
// Oscillator controller: sequences each transaction through the datapath.
module mwo_ctrl import mwo_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [WAVE_W-1:0] i_waveform,
    input  t_status           i_st,
    output logic              o_in_ready,
    output t_cmd              o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.op = OP_PREP;
                n_state  = S_ROM;
            end
            S_ROM: begin
                o_cmd.op = OP_ROM;
                if (i_waveform == WAVE_SINE5) begin
                    n_state = S_POW1;
                end else if (i_waveform == WAVE_MORPH) begin
                    n_state = i_st.k_big ? S_SDIV : S_KDIV;
                end else begin
                    n_state = S_SHAPE;
                end
            end
            S_POW1: begin
                o_cmd.op = OP_POW1;
                n_state  = S_POW2;
            end
            S_POW2: begin
                o_cmd.op = OP_POW2;
                n_state  = S_POW3;
            end
            S_POW3: begin
                o_cmd.op = OP_POW3;
                n_state  = S_SHAPE;
            end
            S_KDIV: begin
                o_cmd.op = OP_KSTART;
                n_state  = S_KWAIT;
            end
            S_KWAIT: begin
                if (i_st.div_done) begin
                    o_cmd.op = OP_KTAKE;
                    n_state  = S_SDIV;
                end
            end
            S_SDIV: begin
                o_cmd.op = OP_SSTART;
                n_state  = S_SWAIT;
            end
            S_SWAIT: begin
                if (i_st.div_done) begin
                    n_state = S_SHAPE;
                end
            end
            S_SHAPE: begin
                o_cmd.op = OP_SHAPE;
                n_state  = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.op = OP_GAIN;
                n_state  = S_HOLD;
            end
            S_HOLD: begin
                if (!i_st.out_busy) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !i_st.div_busy)
        else $error("divider busy while idle");

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KDIV || r_state == S_SDIV) |=> i_st.div_busy)
        else $error("divider did not start");

    a_div_to_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAIT && i_st.div_done) |=> r_state == S_SHAPE)
        else $error("quotient not taken");

endmodule

// File: src/multi_waveform_oscillator.sv
// Path from input transaction to output valid: load, prep, ROM read, shape, gain and output
// for sine, saw, squared saw, triangle and unused codes; sine to the fifth adds three Q15
// products in series; morph saw adds one 32-step divide above the knee, two below it.
// Input is taken again only once the result sits in the output register, and that waits
// while the previous sample is stalled. Reset: synchronous active-low, phase to zero,
// registers to defaults; the sine ROM is constant and needs no fill.
module multi_waveform_oscillator import mwo_pkg::*; #(
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mwo_in_if.sink            i_in,
    mwo_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg    r_cfg;
    t_cmd    w_cmd;
    t_status w_st;
    logic    w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.waveform      <= WAVE_RST;
            r_cfg.amplitude     <= AMP_RST;
            r_cfg.phase_per_hz  <= PPH_RST;
            r_cfg.morph_knee_hz <= KNEE_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_WAVE: r_cfg.waveform      <= pwdata[WAVE_W-1:0];
                REG_AMP:  r_cfg.amplitude     <= pwdata[AMP_W-1:0];
                REG_PPH:  r_cfg.phase_per_hz  <= pwdata[PPH_W-1:0];
                REG_KNEE: r_cfg.morph_knee_hz <= pwdata[KNEE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WAVE: prdata = APB_DW'(r_cfg.waveform);
            REG_AMP:  prdata = APB_DW'(r_cfg.amplitude);
            REG_PPH:  prdata = APB_DW'(r_cfg.phase_per_hz);
            REG_KNEE: prdata = APB_DW'(r_cfg.morph_knee_hz);
            default:  prdata = '0;
        endcase
    end

    mwo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_waveform (r_cfg.waveform),
        .i_st       (w_st),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    mwo_dp #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (r_cfg),
        .i_freq_q8   (i_in.freq_q8),
        .i_out_ready (o_out.ready),
        .o_st        (w_st),
        .o_out_valid (o_out.valid),
        .o_sample    (o_out.sample),
        .o_clipped   (o_out.clipped)
    );

endmodule

// File: verif/multi_waveform_oscillator_tb.sv
// Self-checking testbench for the multi-waveform oscillator: directed table, then random.
module multi_waveform_oscillator_tb;
    import mwo_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        logic        is_cfg;
        logic [23:0] freq;
        logic        has_exp;
        logic [15:0] exp_sample;
        logic        exp_clip;
    } t_row;

    typedef struct {
        logic [15:0] sample;
        logic        clipped;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    mwo_in_if  in_ch ();
    mwo_out_if #(.SAMPLE_BITS(16)) out_ch ();

    multi_waveform_oscillator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // predictor state
    int          sine_rom [0:1024];
    logic [31:0] phase_acc;
    logic [2:0]  m_wave;
    logic [15:0] m_amp;
    logic [23:0] m_pph;
    logic [15:0] m_knee;

    t_res        sample_q [$];
    logic        fixed_q [$];
    t_res        fixed_val_q [$];
    int          errors = 0;
    int          n_checked = 0;
    int          n_clipped = 0;
    int          wave_seen [0:7];

    function automatic longint unsigned sine_q30(longint unsigned x);
        longint unsigned x2, t;
        x2 = (x * x) >> 30;
        t = 64'd1073741824;
        for (int n = 7; n >= 1; n--)
            t = 64'd1073741824 - ((x2 * t) >> 30) / ((2 * n) * (2 * n + 1));
        return (x * t) >> 30;
    endfunction

    function automatic int rom_sine(logic [31:0] ph);
        longint unsigned f, idx;
        int v;
        f = ph[29:0];
        idx = (f * 1024 + (64'd1 << 29)) >> 30;
        if (idx > 1024) idx = 1024;
        v = ph[30] ? sine_rom[1024 - idx] : sine_rom[idx];
        return ph[31] ? -v : v;
    endfunction

    function automatic int q15_mul(int a, int b);
        return int'((longint'(a) * b + 16384) >>> 15);
    endfunction

    function automatic int wave_shape(logic [31:0] ph, logic [23:0] freq);
        int u, s, m, m2;
        longint k, d;
        u = ph[31:16];
        case (m_wave)
            WAVE_SINE: return rom_sine(ph);
            WAVE_SQSAW: begin
                if (u < 32768) return int'((longint'(u) * u + 32768) >> 16);
                d = 65536 - u;
                return -int'((d * d + 32768) >> 16);
            end
            WAVE_SAW: return (u < 32768) ? u / 2 : (u - 65536) / 2;
            WAVE_SINE5: begin
                s = rom_sine(ph);
                m = (s < 0) ? -s : s;
                m2 = q15_mul(m, m);
                m = q15_mul(q15_mul(m2, m2), m);
                return (s < 0) ? -m : m;
            end
            WAVE_TRI: return (u < 32768) ? 32768 - 2 * u : 2 * u - 98304;
            WAVE_MORPH: begin
                if (longint'(freq) >= longint'(m_knee) * 256) k = 32768;
                else k = (longint'(freq) * 128) / m_knee;
                if (k < 1) k = 1;
                if (u < k) return int'(32768 - (65536 * longint'(u)) / k);
                return int'((32768 * (2 * longint'(u) - 65536 - k)) / (65536 - k));
            end
            default: return 0;
        endcase
    endfunction

    function automatic t_res next_sample(logic [23:0] freq);
        t_res res;
        longint prod, r;
        longint unsigned inc;
        prod = longint'(wave_shape(phase_acc, freq)) * m_amp;
        r = (prod + 8192) >>> 14;
        res.clipped = 1'b0;
        if (r > 32767) begin r = 32767; res.clipped = 1'b1; end
        if (r < -32768) begin r = -32768; res.clipped = 1'b1; end
        res.sample = r[15:0];
        inc = (longint'(freq) * m_pph) >> 8;
        phase_acc = phase_acc + inc[31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %0s: got %0d expected %0d (txn %0d)", what, got, want, n_checked);
        errors++;
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_WAVE: m_wave = val[2:0];
            REG_AMP:  m_amp  = val[15:0];
            REG_PPH:  m_pph  = val[23:0];
            default:  m_knee = val[15:0];
        endcase
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sample_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (100) @(posedge i_clk);
    endtask

    task automatic send_freq(logic [23:0] freq, logic has_exp, t_res fixed);
        int gap;
        gap = $urandom_range(0, 13);
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.freq_q8 <= freq;
        sample_q.push_back(next_sample(freq));
        fixed_q.push_back(has_exp);
        fixed_val_q.push_back(fixed);
        wave_seen[m_wave]++;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // sink side with random stalls
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        forever begin
            gap = $urandom_range(0, 13);
            @(negedge i_clk);
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    always @(posedge i_clk) begin
        t_res want, fx;
        logic hf;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (sample_q.size() == 0) begin
                $display("unexpected output transaction");
                errors++;
            end else begin
                want = sample_q.pop_front();
                hf = fixed_q.pop_front();
                fx = fixed_val_q.pop_front();
                if (hf && (fx.sample != want.sample || fx.clipped != want.clipped))
                    report_mismatch("table row", int'(signed'(fx.sample)),
                                    int'(signed'(want.sample)));
                if (out_ch.sample !== want.sample)
                    report_mismatch("sample", int'(out_ch.sample), int'(signed'(want.sample)));
                if (out_ch.clipped !== want.clipped)
                    report_mismatch("clipped", out_ch.clipped, want.clipped);
                n_checked++;
                if (want.clipped) n_clipped++;
            end
        end
    end

    initial begin
        t_row rows [$];
        t_row rw;
        t_res fx;
        logic [23:0] f;
        int w;
        for (int i = 0; i <= 1024; i++) begin
            longint unsigned v;
            v = (sine_q30(longint'(i) * 64'd1686629713 / 1024) + 16384) >> 15;
            sine_rom[i] = (v > 32767) ? 32767 : int'(v);
        end
        phase_acc = '0; m_wave = WAVE_RST; m_amp = AMP_RST; m_pph = PPH_RST; m_knee = KNEE_RST;
        foreach (wave_seen[i]) wave_seen[i] = 0;
        in_ch.valid = 1'b0;
        in_ch.freq_q8 = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: phase zero gives known samples after reset
        rows.push_back('{REG_WAVE, 0, 0, 24'h000100, 1, 16'd26214, 0}); // morph at phase 0
        rows.push_back('{REG_AMP, 32'hFFFF, 1, 0, 0, 0, 0});
        rows.push_back('{REG_PPH, 32'h0, 1, 0, 0, 0, 0});
        rows.push_back('{REG_WAVE, WAVE_TRI, 1, 0, 0, 0, 0});
        rows.push_back('{REG_WAVE, 0, 0, 24'hFFFFFF, 1, 16'h7FFF, 1}); // triangle peak clips
        rows.push_back('{REG_WAVE, WAVE_SINE, 1, 0, 0, 0, 0});
        rows.push_back('{REG_WAVE, 0, 0, 24'h0, 1, 16'd0, 0});
        rows.push_back('{REG_WAVE, 3'd6, 1, 0, 0, 0, 0});
        rows.push_back('{REG_WAVE, 0, 0, 24'hFFFFFF, 1, 16'd0, 0}); // unused code
        rows.push_back('{REG_PPH, 32'hFFFFFF, 1, 0, 0, 0, 0});
        rows.push_back('{REG_WAVE, 3'd7, 1, 0, 0, 0, 0});
        rows.push_back('{REG_WAVE, 0, 0, 24'hABCDEF, 0, 0, 0});
        rows.push_back('{REG_KNEE, 32'h0, 1, 0, 0, 0, 0});
        rows.push_back('{REG_WAVE, WAVE_MORPH, 1, 0, 0, 0, 0});
        rows.push_back('{REG_WAVE, 0, 0, 24'h000001, 0, 0, 0});
        rows.push_back('{REG_KNEE, 32'hFFFF, 1, 0, 0, 0, 0});
        rows.push_back('{REG_WAVE, 0, 0, 24'h000000, 0, 0, 0});
        rows.push_back('{REG_WAVE, 0, 0, 24'h123456, 0, 0, 0});
        rows.push_back('{REG_KNEE, 32'd1, 1, 0, 0, 0, 0});
        rows.push_back('{REG_WAVE, 0, 0, 24'h0000FF, 0, 0, 0});
        rows.push_back('{REG_WAVE, 0, 0, 24'h000100, 0, 0, 0});
        for (int c = 0; c <= 5; c++) begin
            rows.push_back('{REG_WAVE, c, 1, 0, 0, 0, 0});
            rows.push_back('{REG_WAVE, 0, 0, 24'h7FFFFF, 0, 0, 0});
        end
        foreach (rows[i]) begin
            rw = rows[i];
            if (rw.is_cfg) begin
                drain();
                apb_write(rw.reg_idx, rw.reg_val);
            end else begin
                fx.sample = rw.exp_sample;
                fx.clipped = rw.exp_clip;
                send_freq(rw.freq, rw.has_exp, fx);
            end
        end

        // random phases with random configuration, extremes included
        for (int ph = 0; ph < 24; ph++) begin
            drain();
            apb_write(REG_WAVE, (ph < 18) ? ph % 6 : $urandom_range(0, 7));
            case ($urandom_range(0, 3))
                0: apb_write(REG_AMP, 32'hFFFF);
                1: apb_write(REG_AMP, 0);
                default: apb_write(REG_AMP, $urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 3))
                0: apb_write(REG_PPH, 32'hFFFFFF);
                1: apb_write(REG_PPH, PPH_RST);
                default: apb_write(REG_PPH, $urandom_range(0, 24'hFFFFFF));
            endcase
            case ($urandom_range(0, 3))
                0: apb_write(REG_KNEE, 1);
                1: apb_write(REG_KNEE, 32'hFFFF);
                default: apb_write(REG_KNEE, $urandom_range(1, 65535));
            endcase
            for (int k = 0; k < 78; k++) begin
                w = $urandom_range(0, 3);
                f = (w == 0) ? $urandom_range(0, 24'hFFFFFF) :
                    (w == 1) ? $urandom_range(0, 24'h3FFFF) : $urandom_range(0, 24'h3FFF);
                fx.sample = '0;
                fx.clipped = 1'b0;
                send_freq(f, 1'b0, fx);
            end
        end
        drain();

        $display("checked %0d samples, %0d saturated", n_checked, n_clipped);
        $display("per waveform code: %0d %0d %0d %0d %0d %0d %0d %0d", wave_seen[0],
                 wave_seen[1], wave_seen[2], wave_seen[3], wave_seen[4], wave_seen[5],
                 wave_seen[6], wave_seen[7]);
        if (errors == 0 && sample_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
